/* hw/rtl/space_vector_pwm_duty_macros.svh */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: assertion macros
// Clocked property shorthands for the checker; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_MACROS_SVH

// same-cycle implication
`define SVPWM_CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVPWM_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/svpwm_pkg.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: shared package
// Field widths, fixed-point constants, sector codes and beat types.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int IN_WIDTH   = 16;
    localparam int BUS_WIDTH  = IN_WIDTH - 1;
    localparam int DUTY_WIDTH = 16;
    localparam int FRAC_BITS  = 62 - IN_WIDTH;
    localparam int VW         = 64;

    localparam logic [VW-1:0] SQRT3_Q62          = 64'h6ED9_EBA1_6132_A9CE;
    localparam logic [VW-1:0] TWO_OVER_SQRT3_Q62 = (SQRT3_Q62 * 64'd2) / 64'd3;
    localparam logic [VW-1:0] K_ALPHA            = SQRT3_Q62 >> IN_WIDTH;
    localparam logic [VW-1:0] K_ALPHA_NEG        = (~K_ALPHA) + VW'(1);
    localparam logic [VW-1:0] R_BUS              = TWO_OVER_SQRT3_Q62 >> IN_WIDTH;

    localparam logic [2:0] SECTOR_ZERO = 3'd0;
    localparam logic [2:0] SECTOR_1    = 3'd1;
    localparam logic [2:0] SECTOR_2    = 3'd2;
    localparam logic [2:0] SECTOR_3    = 3'd3;
    localparam logic [2:0] SECTOR_4    = 3'd4;
    localparam logic [2:0] SECTOR_5    = 3'd5;
    localparam logic [2:0] SECTOR_6    = 3'd6;
    localparam logic [2:0] SECTOR_BAD  = 3'd7;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] v_alpha;
        logic signed [IN_WIDTH-1:0] v_beta;
        logic [BUS_WIDTH-1:0]       v_bus;
    } svpwm_in_t;

    typedef struct packed {
        logic [DUTY_WIDTH-1:0] duty_a;
        logic [DUTY_WIDTH-1:0] duty_b;
        logic [DUTY_WIDTH-1:0] duty_c;
        logic [2:0]            sector;
        logic                  overmodulated;
        logic                  bus_fault;
    } svpwm_out_t;

    typedef struct packed {
        logic [2:0] sector;
        logic       hold;
        logic       over;
        logic       fault;
    } svpwm_stat_t;

endpackage

/* hw/rtl/svpwm_mul.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: serial constant multiplier
// Forms v_alpha*sqrt3 and v_bus*(2/sqrt3) one operand bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module svpwm_mul
    import svpwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [IN_WIDTH-1:0] alpha,
    input  logic [BUS_WIDTH-1:0] bus,
    output logic                done,
    output logic [VW-1:0]       prod_s,
    output logic [VW-1:0]       prod_d
);

    localparam int CW = $clog2(IN_WIDTH);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [IN_WIDTH-1:0] a_sh_reg;
    logic [IN_WIDTH-1:0] b_sh_reg;
    logic [VW-1:0]       acc_s_reg;
    logic [VW-1:0]       acc_d_reg;

    logic                first_step;
    logic [VW-1:0]       add_s;
    logic [VW-1:0]       add_d;
    logic [VW-1:0]       acc_s_next;
    logic [VW-1:0]       acc_d_next;

    always_comb
    begin
        first_step = (cnt_reg == CW'(IN_WIDTH - 1));
        add_s      = '0;
        if (a_sh_reg[IN_WIDTH-1])
        begin
            add_s = first_step ? K_ALPHA_NEG : K_ALPHA;
        end
        add_d      = b_sh_reg[IN_WIDTH-1] ? R_BUS : '0;
        acc_s_next = {acc_s_reg[VW-2:0], 1'b0} + add_s;
        acc_d_next = {acc_d_reg[VW-2:0], 1'b0} + add_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(IN_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg  <= alpha;
            b_sh_reg  <= {1'b0, bus};
            acc_s_reg <= '0;
            acc_d_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_sh_reg  <= {a_sh_reg[IN_WIDTH-2:0], 1'b0};
            b_sh_reg  <= {b_sh_reg[IN_WIDTH-2:0], 1'b0};
            acc_s_reg <= acc_s_next;
            acc_d_reg <= acc_d_next;
        end
    end

    assign done   = done_reg;
    assign prod_s = acc_s_reg;
    assign prod_d = acc_d_reg;

endmodule

/* hw/rtl/svpwm_vec.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: sector and timing steps
// Five registered steps: line voltages, sector and active times, overmodulation, scaling, compare values.
// ----------------------------------------------------------------------------
module svpwm_vec
    import svpwm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VW-1:0]          s,
    input  logic [IN_WIDTH-1:0]    beta,
    input  logic [VW-1:0]          d,
    input  logic                   fault,
    output logic                   done,
    output svpwm_stat_t            stat,
    output logic [VW-1:0]          den,
    output logic [2:0][VW-1:0]     num
);

    logic [4:0]          stg_reg;
    logic [4:0]          stg_next;

    logic [VW-1:0]       r1_reg;
    logic [VW-1:0]       r2_reg;
    logic [VW-1:0]       tx_reg;
    logic                bneg_reg;
    logic                fault_reg;
    logic [2:0]          sector_reg;
    logic                hold_reg;
    logic [VW-1:0]       n1_reg;
    logic [VW-1:0]       n2_reg;
    logic [VW-1:0]       sum_reg;
    logic                over_reg;
    logic [VW-1:0]       h_reg;
    logic [VW-1:0]       t1_reg;
    logic [VW-1:0]       t2_reg;
    logic [VW-1:0]       tail_reg;
    logic [VW-1:0]       den_reg;
    logic [2:0][VW-1:0]  num_reg;

    logic [VW-1:0]       bx;
    logic [VW-1:0]       r1_next;
    logic [VW-1:0]       r2_next;
    logic [VW-1:0]       tx_next;
    logic                r1_pos;
    logic                r2_pos;
    logic [2:0]          sector_next;
    logic                hold_next;
    logic [VW-1:0]       nr1;
    logic [VW-1:0]       nr2;
    logic [VW-1:0]       ntx;
    logic [VW-1:0]       n1_next;
    logic [VW-1:0]       n2_next;
    logic [VW-1:0]       sum_next;
    logic                over_next;
    logic [VW-1:0]       h_next;
    logic [VW-1:0]       t1_next;
    logic [VW-1:0]       t2_next;
    logic [VW-1:0]       tail_next;
    logic [VW-1:0]       den_next;
    logic [VW-1:0]       mid;
    logic [2:0][VW-1:0]  num_next;

    // step 1: line voltages
    always_comb
    begin
        bx      = {{(VW - IN_WIDTH - FRAC_BITS){beta[IN_WIDTH-1]}}, beta,
                   {FRAC_BITS{1'b0}}};
        r1_next = s + bx;
        r2_next = bx - s;
        tx_next = {bx[VW-2:0], 1'b0};
    end

    // step 2: sector and active times
    always_comb
    begin
        r1_pos      = !r1_reg[VW-1] && (r1_reg != '0);
        r2_pos      = !r2_reg[VW-1] && (r2_reg != '0);
        sector_next = {bneg_reg, r2_pos, r1_pos};
        hold_next   = fault_reg || (sector_next == SECTOR_ZERO) ||
                      (sector_next == SECTOR_BAD);
        nr1         = (~r1_reg) + VW'(1);
        nr2         = (~r2_reg) + VW'(1);
        ntx         = (~tx_reg) + VW'(1);
        case (sector_next)
            SECTOR_1:
            begin
                n1_next = nr2;
                n2_next = tx_reg;
            end
            SECTOR_2:
            begin
                n1_next = tx_reg;
                n2_next = nr1;
            end
            SECTOR_3:
            begin
                n1_next = r1_reg;
                n2_next = r2_reg;
            end
            SECTOR_4:
            begin
                n1_next = nr1;
                n2_next = nr2;
            end
            SECTOR_5:
            begin
                n1_next = ntx;
                n2_next = r1_reg;
            end
            SECTOR_6:
            begin
                n1_next = r2_reg;
                n2_next = ntx;
            end
            default:
            begin
                n1_next = '0;
                n2_next = '0;
            end
        endcase
    end

    // step 3: total active time against one period
    always_comb
    begin
        sum_next  = n1_reg + n2_reg;
        over_next = (sum_next > d);
    end

    // step 4: scale to the period or normalize by the sum
    always_comb
    begin
        if (over_reg)
        begin
            den_next  = sum_reg;
            h_next    = '0;
            t1_next   = n1_reg;
            t2_next   = n2_reg;
            tail_next = sum_reg;
        end
        else
        begin
            den_next  = {d[VW-2:0], 1'b0};
            h_next    = d - sum_reg;
            t1_next   = {n1_reg[VW-2:0], 1'b0};
            t2_next   = {n2_reg[VW-2:0], 1'b0};
            tail_next = d + sum_reg;
        end
    end

    // step 5: stack the times in per-sector phase order
    always_comb
    begin
        case (sector_reg)
            SECTOR_1, SECTOR_2, SECTOR_4: mid = h_reg + t1_reg;
            default:                      mid = h_reg + t2_reg;
        endcase
        case (sector_reg)
            SECTOR_1:
            begin
                num_next[0] = h_reg;
                num_next[1] = mid;
                num_next[2] = tail_reg;
            end
            SECTOR_2:
            begin
                num_next[1] = h_reg;
                num_next[2] = mid;
                num_next[0] = tail_reg;
            end
            SECTOR_3:
            begin
                num_next[1] = h_reg;
                num_next[0] = mid;
                num_next[2] = tail_reg;
            end
            SECTOR_4:
            begin
                num_next[2] = h_reg;
                num_next[0] = mid;
                num_next[1] = tail_reg;
            end
            SECTOR_5:
            begin
                num_next[0] = h_reg;
                num_next[2] = mid;
                num_next[1] = tail_reg;
            end
            default:
            begin
                num_next[2] = h_reg;
                num_next[1] = mid;
                num_next[0] = tail_reg;
            end
        endcase
    end

    assign stg_next = {stg_reg[3:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg <= '0;
        end
        else
        begin
            stg_reg <= stg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            tx_reg    <= tx_next;
            bneg_reg  <= beta[IN_WIDTH-1];
            fault_reg <= fault;
        end
        if (stg_reg[0])
        begin
            sector_reg <= sector_next;
            hold_reg   <= hold_next;
            n1_reg     <= n1_next;
            n2_reg     <= n2_next;
        end
        if (stg_reg[1])
        begin
            sum_reg  <= sum_next;
            over_reg <= over_next;
        end
        if (stg_reg[2])
        begin
            den_reg  <= den_next;
            h_reg    <= h_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            tail_reg <= tail_next;
        end
        if (stg_reg[3])
        begin
            num_reg <= num_next;
        end
    end

    assign done        = stg_reg[4];
    assign stat.sector = sector_reg;
    assign stat.hold   = hold_reg;
    assign stat.over   = over_reg && !hold_reg;
    assign stat.fault  = fault_reg;
    assign den         = den_reg;
    assign num         = num_reg;

endmodule

/* hw/rtl/svpwm_div.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: fraction divider
// Three restoring divider lanes, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module svpwm_div
    import svpwm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2:0][VW-1:0]           num,
    input  logic [VW-1:0]                den,
    output logic                         done,
    output logic [2:0][DUTY_WIDTH-1:0]   quo
);

    localparam int CW = $clog2(DUTY_WIDTH);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CW-1:0]              cnt_reg;
    logic [VW-1:0]              den_reg;
    logic [2:0][VW-1:0]         rem_reg;
    logic [2:0][DUTY_WIDTH-1:0] q_reg;
    logic [2:0]                 sat_reg;

    logic [2:0][VW:0]           two_r;
    logic [2:0][VW:0]           diff;
    logic [2:0]                 ge;
    logic [2:0][VW-1:0]         rem_next;
    logic [2:0][DUTY_WIDTH-1:0] q_next;
    logic [2:0]                 sat_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            two_r[i]    = {rem_reg[i], 1'b0};
            diff[i]     = two_r[i] - {1'b0, den_reg};
            ge[i]       = (two_r[i] >= {1'b0, den_reg});
            rem_next[i] = ge[i] ? diff[i][VW-1:0] : two_r[i][VW-1:0];
            q_next[i]   = {q_reg[i][DUTY_WIDTH-2:0], ge[i]};
            sat_next[i] = (num[i] >= den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DUTY_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= num;
            q_reg   <= '0;
            sat_reg <= sat_next;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo[i] = sat_reg[i] ? {DUTY_WIDTH{1'b1}} : q_reg[i];
        end
    end

    assign done = done_reg;

endmodule

/* hw/rtl/space_vector_pwm_duty.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: top level
// A reference beat is taken only in idle and runs through the bit-serial
// multiplier, the sector and timing steps and the bit-serial divider lanes
// in turn; the divider is skipped when the duties are held (zero reference or
// bus fault). No new reference is taken until the result beat is loaded.
// Reset clears the sequencer, the output valid and the held duties to zero.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty
    import svpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       ref_valid,
    output logic       ref_stall,
    input  svpwm_in_t  ref_data,
    output logic       duty_valid,
    input  logic       duty_stall,
    output svpwm_out_t duty_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_VEC  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    svpwm_in_t                  in_reg;
    svpwm_out_t                 out_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [2:0][DUTY_WIDTH-1:0] last_duty_reg;

    logic                       accept;
    logic                       load_out;
    logic                       mul_done;
    logic [VW-1:0]              prod_s;
    logic [VW-1:0]              prod_d;
    logic                       vec_start;
    logic                       vec_done;
    svpwm_stat_t                vec_stat;
    logic [VW-1:0]              vec_den;
    logic [2:0][VW-1:0]         vec_num;
    logic                       div_start;
    logic                       div_done;
    logic [2:0][DUTY_WIDTH-1:0] div_quo;

    assign accept    = ref_valid && (state_reg == ST_IDLE);
    assign vec_start = (state_reg == ST_MUL) && mul_done;
    assign div_start = (state_reg == ST_VEC) && vec_done && !vec_stat.hold;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || !duty_stall);

    svpwm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .alpha  (ref_data.v_alpha),
        .bus    (ref_data.v_bus),
        .done   (mul_done),
        .prod_s (prod_s),
        .prod_d (prod_d)
    );

    svpwm_vec u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .start (vec_start),
        .s     (prod_s),
        .beta  (in_reg.v_beta),
        .d     (prod_d),
        .fault (in_reg.v_bus == '0),
        .done  (vec_done),
        .stat  (vec_stat),
        .den   (vec_den),
        .num   (vec_num)
    );

    svpwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (vec_num),
        .den   (vec_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_VEC;
                end
            end
            ST_VEC:
            begin
                if (vec_done)
                begin
                    state_next = vec_stat.hold ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && duty_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_duty_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == ST_DIV) && div_done)
            begin
                last_duty_reg <= div_quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= ref_data;
        end
        if (load_out)
        begin
            out_reg.duty_a        <= last_duty_reg[0];
            out_reg.duty_b        <= last_duty_reg[1];
            out_reg.duty_c        <= last_duty_reg[2];
            out_reg.sector        <= vec_stat.sector;
            out_reg.overmodulated <= vec_stat.over;
            out_reg.bus_fault     <= vec_stat.fault;
        end
    end

    assign ref_stall  = (state_reg != ST_IDLE);
    assign duty_valid = out_valid_reg;
    assign duty_data  = out_reg;

endmodule

/* hw/rtl/svpwm_chk.sv */
// ----------------------------------------------------------------------------
// Space-vector PWM duty generator: port checker
// Watches the top-level beats; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "space_vector_pwm_duty_macros.svh"

module svpwm_chk
    import svpwm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       ref_valid,
    input logic       ref_stall,
    input logic       duty_valid,
    input logic       duty_stall,
    input svpwm_out_t duty_data
);

    `SVPWM_CHK_NEXT(a_one_in_flight, ref_valid && !ref_stall, ref_stall, "beat taken while busy")
    `SVPWM_CHK_NEXT(a_out_hold, duty_valid && duty_stall, duty_valid && $stable(duty_data), "stalled beat changed")
    `SVPWM_CHK_SAME(a_fault_no_over, duty_valid && duty_data.bus_fault, !duty_data.overmodulated, "overmodulated on bus fault")
    `SVPWM_CHK_SAME(a_zero_no_over, duty_valid && (duty_data.sector == SECTOR_ZERO), !duty_data.overmodulated, "overmodulated on zero reference")

endmodule

bind space_vector_pwm_duty svpwm_chk u_svpwm_chk (.*);
